// File: design/lz77_apd_pkg.sv
// Package for the LZ77 absolute-position decoder.
// Sizes, controller states and the command/status bundles; no dependencies.
package lz77_apd_pkg;

  localparam int HISTORY_DEPTH = 65536;
  localparam int MAX_MATCH     = 64;

  localparam int ADDR_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W  = ADDR_W + 1;
  // width that holds position + length and count + length without wrap
  localparam int SUM_W  = ((CNT_W > 17) ? CNT_W : 17) + 1;
  localparam int LEN_W  = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic take_token;
    logic emit_lit;
    logic emit_err;
    logic rd_first;
    logic load_byte;
  } cmd_t;

  typedef struct packed {
    logic stopped;
    logic is_lit;
    logic lit_ok;
    logic copy_ok;
    logic last;
  } status_t;

endpackage

// File: design/lz77_apd_ctrl.sv
// Controller FSM for the LZ77 absolute-position decoder.
// Depends on lz77_apd_pkg; drives the datapath by cmd_t, reads status_t.
module lz77_apd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  lz77_apd_pkg::status_t  status,
  output lz77_apd_pkg::cmd_t     cmd
);

  lz77_apd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lz77_apd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      lz77_apd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_token = 1'b1;
          state_next     = lz77_apd_pkg::ST_CHECK;
        end
      end
      lz77_apd_pkg::ST_CHECK: begin
        if (status.stopped) begin
          state_next = lz77_apd_pkg::ST_IDLE;
        end else if (status.is_lit) begin
          cmd.emit_lit = status.lit_ok;
          cmd.emit_err = !status.lit_ok;
          state_next   = lz77_apd_pkg::ST_EMIT;
        end else if (status.copy_ok) begin
          cmd.rd_first = 1'b1;
          state_next   = lz77_apd_pkg::ST_LOAD;
        end else begin
          cmd.emit_err = 1'b1;
          state_next   = lz77_apd_pkg::ST_EMIT;
        end
      end
      lz77_apd_pkg::ST_LOAD: begin
        cmd.load_byte = 1'b1;
        state_next    = lz77_apd_pkg::ST_EMIT;
      end
      lz77_apd_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.last) begin
            state_next = lz77_apd_pkg::ST_IDLE;
          end else begin
            // next byte's read was issued on the previous load
            cmd.load_byte = 1'b1;
          end
        end
      end
      default: begin
        state_next = lz77_apd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/lz77_apd_datapath.sv
// Datapath for the LZ77 absolute-position decoder: token registers, counters,
// history memory and the output register. Depends on lz77_apd_pkg.
module lz77_apd_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  lz77_apd_pkg::cmd_t     cmd,
  output lz77_apd_pkg::status_t  status,
  input  logic                   stream_start,
  input  logic [15:0]            match_position,
  input  logic [6:0]             match_length,
  output logic [7:0]             out_byte,
  output logic                   last_of_token,
  output logic                   decode_error
);

  localparam int AW = lz77_apd_pkg::ADDR_W;
  localparam int CW = lz77_apd_pkg::CNT_W;
  localparam int SW = lz77_apd_pkg::SUM_W;
  localparam int LW = lz77_apd_pkg::LEN_W;

  logic [7:0]    history [lz77_apd_pkg::HISTORY_DEPTH];
  logic [7:0]    rdata;

  logic [15:0]   tok_pos;
  logic [LW-1:0] tok_len;
  logic [CW-1:0] count;
  logic          stopped;
  logic [LW-1:0] rem;
  logic [AW-1:0] src;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          more;

  logic [SW-1:0] end_src;
  logic [SW-1:0] end_dst;

  assign more    = rem > LW'(1);
  assign wr_en   = cmd.emit_lit | cmd.load_byte;
  assign wr_addr = count[AW-1:0];
  assign wr_data = cmd.load_byte ? rdata : tok_pos[7:0];
  assign rd_en   = cmd.rd_first | (cmd.load_byte & more);
  assign rd_addr = cmd.rd_first ? AW'(tok_pos) : src;

  assign end_src = SW'(tok_pos) + SW'(tok_len);
  assign end_dst = SW'(count) + SW'(tok_len);

  assign status.stopped = stopped;
  assign status.is_lit  = tok_len == '0;
  assign status.lit_ok  = SW'(count) < SW'(lz77_apd_pkg::HISTORY_DEPTH);
  assign status.copy_ok = (SW'(tok_len) <= SW'(lz77_apd_pkg::MAX_MATCH))
                        && (end_src <= SW'(count))
                        && (end_dst <= SW'(lz77_apd_pkg::HISTORY_DEPTH));
  assign status.last    = last_of_token;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      history[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= history[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      stopped <= 1'b0;
    end else begin
      if (cmd.take_token && stream_start) begin
        count   <= '0;
        stopped <= 1'b0;
      end
      if (cmd.emit_err) begin
        stopped <= 1'b1;
      end
      if (cmd.emit_lit || cmd.load_byte) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_token) begin
      tok_pos <= match_position;
      tok_len <= match_length;
    end
    if (cmd.rd_first) begin
      src <= AW'(tok_pos) + AW'(1);
      rem <= tok_len;
    end
    if (cmd.load_byte) begin
      rem <= rem - LW'(1);
      if (more) begin
        src <= src + AW'(1);
      end
    end
    if (cmd.emit_lit) begin
      out_byte      <= tok_pos[7:0];
      last_of_token <= 1'b1;
      decode_error  <= 1'b0;
    end
    if (cmd.emit_err) begin
      out_byte      <= 8'h00;
      last_of_token <= 1'b1;
      decode_error  <= 1'b1;
    end
    if (cmd.load_byte) begin
      out_byte      <= rdata;
      last_of_token <= !more;
      decode_error  <= 1'b0;
    end
  end

endmodule

// File: design/lz77_absolute_position_decoder.sv
// LZ77 absolute-position decoder, top level: controller plus datapath.
// A literal or error result is registered in ST_CHECK and shown in ST_EMIT; a copy
// reads its first byte in ST_CHECK, loads it in ST_LOAD and shows it in ST_EMIT,
// then streams 1 byte per cycle while out_ready holds, one history read per byte.
// Reset clears state, byte count and stop; history is kept.
module lz77_absolute_position_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        stream_start,
  input  logic [15:0] match_position,
  input  logic [6:0]  match_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last_of_token,
  output logic        decode_error
);

  lz77_apd_pkg::cmd_t    cmd;
  lz77_apd_pkg::status_t status;

  lz77_apd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lz77_apd_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .stream_start   (stream_start),
    .match_position (match_position),
    .match_length   (match_length),
    .out_byte       (out_byte),
    .last_of_token  (last_of_token),
    .decode_error   (decode_error)
  );

  // one request in flight: never taking input while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while result pending");

  a_err_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && decode_error |-> out_byte == 8'h00 && last_of_token)
    else $error("malformed error result");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_of_token |=> !out_valid && in_ready)
    else $error("result after last of token");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule
